// ----- hw/rtl/i2cdws_pkg.sv -----
// Shared types and constants for the display write serializer.
package i2cdws_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'h78;
	localparam logic [7:0] CTRL_CMD = 8'h00;
	localparam logic [7:0] CTRL_DATA = 8'h40;

	localparam logic [1:0] SYM_START = 2'd0;
	localparam logic [1:0] SYM_BIT = 2'd1;
	localparam logic [1:0] SYM_ACK = 2'd2;
	localparam logic [1:0] SYM_STOP = 2'd3;

	// Register index 0 sits at byte address 0; paddr[2] selects the index.
	localparam logic REG_SLAVE_ADDR = 1'b0;

	typedef struct packed {
		logic       is_data;
		logic [7:0] payload;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] symbol_kind;
		logic       sda_level;
		logic       last_of_run;
	} out_beat_t;

	// One queued transaction: the three bytes in send order.
	typedef struct packed {
		logic [7:0] addr_byte;
		logic [7:0] ctrl_byte;
		logic [7:0] data_byte;
	} frame_t;

endpackage

// ----- hw/rtl/i2c_display_write_serializer_top.sv -----
// Top level of the I2C display write serializer.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | in_valid / in_ready        | is_data, payload
//  out     | output    | out_valid / out_ready      | symbol_kind, sda_level, last
//  apb     | input     | psel, penable, pwrite, ... | slave address byte
//
// Each accepted write produces 29 output beats, one per cycle while out_ready
// is high; the symbol sequencer sets that pace.
// The queue holds QUEUE_DEPTH frames, letting writes arrive while a run is out.
// Reset restores the slave address byte to 0x78 and empties the queue.
// A low out_ready stalls only the sequencer; the front keeps taking beats until
// the queue fills.
module i2c_display_write_serializer_top #(
	parameter int unsigned QUEUE_DEPTH = i2cdws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cdws_pkg::PADDR_W-1:0]    paddr,
	input  logic [i2cdws_pkg::PDATA_W-1:0]    pwdata,
	output logic [i2cdws_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  i2cdws_pkg::in_beat_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output i2cdws_pkg::out_beat_t             out_data
);
	import i2cdws_pkg::*;

	logic   push_valid;
	logic   push_ready;
	frame_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	frame_t pop_data;

	assign pready = 1'b1;

	i2cdws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	i2cdws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	i2cdws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/i2cdws_front.sv -----
// Front end: address register, APB access and frame assembly.
module i2cdws_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cdws_pkg::PADDR_W-1:0]    paddr,
	input  logic [i2cdws_pkg::PDATA_W-1:0]    pwdata,
	output logic [i2cdws_pkg::PDATA_W-1:0]    prdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  i2cdws_pkg::in_beat_t              in_data,
	output logic                              push_valid,
	input  logic                              push_ready,
	output i2cdws_pkg::frame_t                push_data
);
	import i2cdws_pkg::*;

	logic [7:0] slave_addr_q;
	logic       reg_hit;

	assign reg_hit = (paddr[PADDR_W-1] == REG_SLAVE_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			slave_addr_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata[7:0] = slave_addr_q;
		end
	end

	assign push_valid = in_valid;
	assign in_ready = push_ready;

	always_comb begin
		push_data.addr_byte = slave_addr_q;
		push_data.ctrl_byte = in_data.is_data ? CTRL_DATA : CTRL_CMD;
		push_data.data_byte = in_data.payload;
	end

endmodule

// ----- hw/rtl/i2cdws_queue.sv -----
// Small frame queue between front end and symbol sequencer.
module i2cdws_queue #(
	parameter int unsigned DEPTH = i2cdws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  i2cdws_pkg::frame_t   push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output i2cdws_pkg::frame_t   pop_data
);
	import i2cdws_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/i2cdws_back.sv -----
// Back end: walks one frame into start, 27 bit/ack clocks and stop.
module i2cdws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  i2cdws_pkg::frame_t   pop_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output i2cdws_pkg::out_beat_t out_data
);
	import i2cdws_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_BITS,
		ST_STOP
	} state_t;

	state_t      state_q;
	logic [23:0] shift_q;
	logic [3:0]  bit_cnt_q;
	logic [1:0]  byte_cnt_q;
	logic        level_q;
	logic        out_valid_q;
	out_beat_t   out_data_q;
	logic        advance;

	// Output register is free or being drained this cycle.
	assign advance = !out_valid_q || out_ready;
	assign pop_ready = advance && ((state_q == ST_IDLE) || (state_q == ST_STOP));
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q <= '0;
			byte_cnt_q <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						out_valid_q <= 1'b1;
						out_data_q <= '{symbol_kind: SYM_START, sda_level: 1'b0,
							last_of_run: 1'b0};
						shift_q <= pop_data;
						bit_cnt_q <= '0;
						byte_cnt_q <= '0;
						state_q <= ST_BITS;
					end
				end
				ST_START: begin
					out_valid_q <= 1'b1;
					out_data_q <= '{symbol_kind: SYM_START, sda_level: 1'b0,
						last_of_run: 1'b0};
					bit_cnt_q <= '0;
					byte_cnt_q <= '0;
					state_q <= ST_BITS;
				end
				ST_BITS: begin
					out_valid_q <= 1'b1;
					if (bit_cnt_q != 4'd8) begin
						out_data_q <= '{symbol_kind: SYM_BIT, sda_level: shift_q[23],
							last_of_run: 1'b0};
						level_q <= shift_q[23];
						shift_q <= {shift_q[22:0], 1'b0};
						bit_cnt_q <= bit_cnt_q + 4'd1;
					end else begin
						// ack clock: unsampled, SDA holds the last data bit
						out_data_q <= '{symbol_kind: SYM_ACK, sda_level: level_q,
							last_of_run: 1'b0};
						bit_cnt_q <= '0;
						if (byte_cnt_q == 2'd2) begin
							state_q <= ST_STOP;
						end else begin
							byte_cnt_q <= byte_cnt_q + 2'd1;
						end
					end
				end
				ST_STOP: begin
					out_valid_q <= 1'b1;
					out_data_q <= '{symbol_kind: SYM_STOP, sda_level: 1'b1,
						last_of_run: 1'b1};
					if (pop_valid) begin
						shift_q <= pop_data;
						state_q <= ST_START;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the I2C display write serializer.
`timescale 1ns / 100ps

module tb;
	import i2cdws_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_SLAVE = {REG_SLAVE_ADDR, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = {~REG_SLAVE_ADDR, 2'b00};
	localparam int RUN_LEN = 29;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;

	typedef enum logic {ROW_WRITE, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [PADDR_W-1:0]  addr;
		logic [31:0]         wdata;
		in_beat_t            beat;
		logic                typed;
		logic [RUN_LEN-1:0]  sda_run;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	in_beat_t in_data;
	logic out_valid, out_ready;
	out_beat_t out_data;

	out_beat_t bus_symbols_due[$];
	dir_row_t directed_rows[$];
	logic [7:0] slave_addr_shadow;
	logic beat_typed;
	logic [RUN_LEN-1:0] beat_sda_run;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;

	i2c_display_write_serializer_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// One write becomes start, three bytes each with an ack clock, then stop.
	// Position 0 of sda_run sits in the MSB.
	function automatic void expand_write_to_symbols(in_beat_t b, logic typed,
			logic [RUN_LEN-1:0] typed_run);
		logic [7:0] ctrl;
		logic [RUN_LEN-1:0] run;
		out_beat_t sym;
		ctrl = b.is_data ? CTRL_DATA : CTRL_CMD;
		run = {1'b0, slave_addr_shadow, slave_addr_shadow[0], ctrl, ctrl[0],
			b.payload, b.payload[0], 1'b1};
		if (typed)
			run = typed_run;
		for (int pos = 0; pos < RUN_LEN; pos++) begin
			if (pos == 0)
				sym.symbol_kind = SYM_START;
			else if (pos == RUN_LEN - 1)
				sym.symbol_kind = SYM_STOP;
			else if (pos % 9 == 0)
				sym.symbol_kind = SYM_ACK;
			else
				sym.symbol_kind = SYM_BIT;
			sym.sda_level = run[RUN_LEN-1-pos];
			sym.last_of_run = (pos == RUN_LEN - 1);
			bus_symbols_due.push_back(sym);
		end
	endfunction

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expand_write_to_symbols(in_data, beat_typed, beat_sda_run);
			if (out_valid && out_ready) begin
				if (bus_symbols_due.size() == 0) begin
					flag_mismatch($sformatf("tb: unexpected beat kind %0d sda %0b last %0b",
						out_data.symbol_kind, out_data.sda_level, out_data.last_of_run));
				end else begin
					want = bus_symbols_due.pop_front();
					if (out_data.symbol_kind !== want.symbol_kind ||
							out_data.sda_level !== want.sda_level ||
							out_data.last_of_run !== want.last_of_run)
						flag_mismatch($sformatf(
							"tb: beat mismatch: exp kind %0d sda %0b last %0b, got kind %0d sda %0b last %0b",
							want.symbol_kind, want.sda_level, want.last_of_run,
							out_data.symbol_kind, out_data.sda_level, out_data.last_of_run));
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_write(in_beat_t b, logic typed, logic [RUN_LEN-1:0] run);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		beat_typed = typed;
		beat_sda_run = run;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_symbols_due.size() != 0) @(negedge clk);
	endtask

	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_SLAVE)
			slave_addr_shadow = data[7:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_slave_addr_readback();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SLAVE;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(PDATA_W-8){1'b0}}, slave_addr_shadow})
			flag_mismatch($sformatf("tb: readback mismatch: exp %0h got %0h",
				slave_addr_shadow, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic dir_row_t write_row(logic is_data, logic [7:0] payload, logic typed,
			logic [RUN_LEN-1:0] run);
		return '{ROW_WRITE, ADDR_SLAVE, 32'h0, '{is_data, payload}, typed, run};
	endfunction

	function automatic dir_row_t config_row(logic [PADDR_W-1:0] addr, logic [31:0] data);
		return '{ROW_CONFIG, addr, data, '{1'b0, 8'h00}, 1'b0, '0};
	endfunction

	initial begin
		in_beat_t b;
		dir_row_t row;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		beat_typed = 1'b0;
		beat_sda_run = '0;
		slave_addr_shadow = SLAVE_ADDR_RESET;

		// address byte at reset value
		directed_rows.push_back(write_row(1'b0, 8'h00, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1}));
		directed_rows.push_back(write_row(1'b1, 8'hFF, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h40, 1'b0, 8'hFF, 1'b1, 1'b1}));
		directed_rows.push_back(write_row(1'b0, 8'hFF, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1}));
		directed_rows.push_back(write_row(1'b1, 8'h00, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h40, 1'b0, 8'h00, 1'b0, 1'b1}));
		directed_rows.push_back(write_row(1'b0, 8'h80, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h00, 1'b0, 8'h80, 1'b0, 1'b1}));
		directed_rows.push_back(write_row(1'b1, 8'h01, 1'b1,
			{1'b0, 8'h78, 1'b0, 8'h40, 1'b0, 8'h01, 1'b1, 1'b1}));
		directed_rows.push_back(write_row(1'b0, 8'hAE, 1'b0, '0));
		directed_rows.push_back(write_row(1'b1, 8'h55, 1'b0, '0));
		// upper write bits are dropped
		directed_rows.push_back(config_row(ADDR_SLAVE, 32'hFFFF_FF00));
		directed_rows.push_back(write_row(1'b0, 8'h00, 1'b1,
			{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1}));
		directed_rows.push_back(write_row(1'b1, 8'hA5, 1'b0, '0));
		// write to a nonexistent register leaves the address byte alone
		directed_rows.push_back(config_row(ADDR_UNUSED, 32'h0000_00FF));
		directed_rows.push_back(write_row(1'b1, 8'hFF, 1'b1,
			{1'b0, 8'h00, 1'b0, 8'h40, 1'b0, 8'hFF, 1'b1, 1'b1}));
		directed_rows.push_back(config_row(ADDR_SLAVE, 32'h0000_00FF));
		directed_rows.push_back(write_row(1'b1, 8'h00, 1'b1,
			{1'b0, 8'hFF, 1'b1, 8'h40, 1'b0, 8'h00, 1'b0, 1'b1}));
		directed_rows.push_back(write_row(1'b0, 8'hFF, 1'b1,
			{1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1}));
		directed_rows.push_back(write_row(1'b1, 8'h3C, 1'b0, '0));
		directed_rows.push_back(config_row(ADDR_SLAVE, 32'h0000_003C));
		directed_rows.push_back(write_row(1'b0, 8'h7F, 1'b0, '0));
		directed_rows.push_back(write_row(1'b1, 8'hC3, 1'b0, '0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_slave_addr_readback();

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CONFIG) begin
				pause_until_drained();
				reg_write(row.addr, row.wdata);
				check_slave_addr_readback();
			end else begin
				send_write(row.beat, row.typed, row.sda_run);
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			pause_until_drained();
			reg_write(ADDR_SLAVE, $urandom());
			if (phase == 2)
				reg_write(ADDR_UNUSED, $urandom());
			check_slave_addr_readback();
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// back-pressure the block until its input stalls
				if (phase == 0 && n == 20)
					hold_req = 1;
				if (n == 60)
					pause_until_drained();
				b.is_data = 1'($urandom_range(0, 1));
				b.payload = 8'($urandom_range(0, 255));
				send_write(b, 1'b0, '0);
			end
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && bus_symbols_due.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
